@@ src/i2cblm_pkg.sv @@
`timescale 1ns / 1ps

package i2cblm_pkg;

   // command codes carried by req_type
   localparam logic [2:0] CMD_START = 3'd0;
   localparam logic [2:0] CMD_STOP  = 3'd1;
   localparam logic [2:0] CMD_WRITE = 3'd2;
   localparam logic [2:0] CMD_READ  = 3'd3;
   localparam logic [2:0] CMD_WAIT  = 3'd4;

   // sequencer phases
   localparam logic [4:0] PH_IDLE    = 5'd0;
   localparam logic [4:0] PH_ST_A    = 5'd1;
   localparam logic [4:0] PH_ST_B    = 5'd2;
   localparam logic [4:0] PH_SP_A    = 5'd3;
   localparam logic [4:0] PH_SP_B    = 5'd4;
   localparam logic [4:0] PH_SP_C    = 5'd5;
   localparam logic [4:0] PH_WR_PRE  = 5'd6;
   localparam logic [4:0] PH_WR_DATA = 5'd7;
   localparam logic [4:0] PH_WR_HIGH = 5'd8;
   localparam logic [4:0] PH_RD_LOW  = 5'd9;
   localparam logic [4:0] PH_RD_HIGH = 5'd10;
   localparam logic [4:0] PH_RD_HOLD = 5'd11;
   localparam logic [4:0] PH_RD_ACKL = 5'd12;
   localparam logic [4:0] PH_RD_ACKH = 5'd13;
   localparam logic [4:0] PH_WA_REL  = 5'd14;
   localparam logic [4:0] PH_WA_HIGH = 5'd15;
   localparam logic [4:0] PH_WA_POLL = 5'd16;

   // configuration register indexes
   localparam logic REG_HALF_DELAY  = 1'b0;
   localparam logic REG_ACK_TIMEOUT = 1'b1;

   localparam logic [15:0] HALF_DELAY_RESET  = 16'd5;
   localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;
   localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

   typedef struct packed {
      logic [4:0]  phase;
      logic [2:0]  cmd;
      logic [15:0] delay;
      logic [3:0]  bits;
      logic [7:0]  shift;
      logic [7:0]  poll;
      logic        ack_choice;
      logic        scl;
      logic        sda;
      logic        drv;
      logic [7:0]  rx;
      logic        tflag;
   } seq_state_type;

   localparam seq_state_type SEQ_RESET = '{
      phase: PH_IDLE, cmd: 3'd0, delay: 16'd0, bits: 4'd0, shift: 8'd0,
      poll: 8'd0, ack_choice: 1'b0, scl: 1'b1, sda: 1'b1, drv: 1'b0,
      rx: 8'd0, tflag: 1'b0};

   typedef struct packed {
      logic       valid;
      logic [2:0] kind;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } seq_cmd_type;

endpackage

@@ src/i2c_bit_level_master_core.sv @@
`timescale 1ns / 1ps

// result: the result of an item sits in the output register in the cycle after it is taken
// throughput: one item per cycle while the output side accepts, each item is one bus tick of the sequencer
// a waiting result does not block the next item unless the output side stalls
// reset (synchronous, active high): idle, scl high, sda released, registers at defaults
module i2c_bit_level_master_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // req_valid, req_type[2:0], tx_byte[7:0], send_ack, sda_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // scl, sda_out, sda_drive, busy_res, done_res,
                                    // rx_byte[7:0], ack_missing
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import i2cblm_pkg::*;

   seq_state_type state_ff, state_in;
   seq_cmd_type   cmd;
   logic [15:0]   half_delay_ff;
   logic [7:0]    ack_timeout_ff;
   logic          rsp_valid_ff;
   logic [15:0]   rsp_data_ff, rsp_data_in;
   logic          done;
   logic          take;

   assign cmd.valid    = req_tdata[0];
   assign cmd.kind     = req_tdata[3:1];
   assign cmd.tx_byte  = req_tdata[11:4];
   assign cmd.send_ack = req_tdata[12];
   assign cmd.sda_in   = req_tdata[13];

   i2cblm_step u_step (
      .cur         (state_ff),
      .cmd_in      (cmd),
      .half_delay  (half_delay_ff),
      .ack_timeout (ack_timeout_ff),
      .nxt         (state_in),
      .done        (done)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;

   assign rsp_data_in = {2'b00, state_in.tflag, state_in.rx, done,
                         (state_in.phase != PH_IDLE), state_in.drv,
                         state_in.sda, state_in.scl};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= SEQ_RESET;
         half_delay_ff  <= HALF_DELAY_RESET;
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_HALF_DELAY:  half_delay_ff  <= csr_wdata;
               REG_ACK_TIMEOUT: ack_timeout_ff <= csr_wdata[7:0];
               default:         ;
            endcase
         end
         if (take) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ src/i2cblm_step.sv @@
`timescale 1ns / 1ps

module i2cblm_step (
   input  i2cblm_pkg::seq_state_type cur,
   input  i2cblm_pkg::seq_cmd_type   cmd_in,
   input  logic [15:0]               half_delay,
   input  logic [7:0]                ack_timeout,
   output i2cblm_pkg::seq_state_type nxt,
   output logic                      done
);
   import i2cblm_pkg::*;

   logic [15:0] dly_load;

   assign dly_load = (half_delay != 16'd0) ? half_delay : 16'd1;

   always_comb begin
      nxt  = cur;
      done = 1'b0;
      if (cur.phase == PH_IDLE) begin
         if (cmd_in.valid && cmd_in.kind <= CMD_WAIT) begin
            nxt.cmd   = cmd_in.kind;
            nxt.bits  = 4'd0;
            nxt.delay = dly_load;
            unique case (cmd_in.kind)
               CMD_START: begin
                  nxt.scl = 1'b1; nxt.drv = 1'b1; nxt.sda = 1'b1;
                  nxt.phase = PH_ST_A;
               end
               CMD_STOP: begin
                  nxt.scl = 1'b0; nxt.drv = 1'b1; nxt.sda = 1'b0;
                  nxt.phase = PH_SP_A;
               end
               CMD_WRITE: begin
                  nxt.shift = cmd_in.tx_byte; nxt.scl = 1'b0;
                  nxt.phase = PH_WR_PRE;
               end
               CMD_READ: begin
                  nxt.ack_choice = cmd_in.send_ack; nxt.shift = 8'd0;
                  nxt.drv = 1'b0; nxt.sda = 1'b1; nxt.scl = 1'b0;
                  nxt.phase = PH_RD_LOW;
               end
               default: begin
                  nxt.drv = 1'b0; nxt.sda = 1'b1;
                  nxt.phase = PH_WA_REL;
               end
            endcase
         end
      end else if (cur.phase == PH_SP_B) begin
         nxt.drv = 1'b1; nxt.sda = 1'b1;
         nxt.phase = PH_SP_C; nxt.delay = dly_load;
      end else if (cur.phase == PH_WA_POLL) begin
         if (!cmd_in.sda_in) begin
            nxt.scl = 1'b0; nxt.tflag = 1'b0; done = 1'b1;
         end else if (cur.poll >= ack_timeout) begin
            // no acknowledge: fall into the stop sequence
            nxt.scl = 1'b0; nxt.drv = 1'b1; nxt.sda = 1'b0;
            nxt.phase = PH_SP_A; nxt.delay = dly_load;
         end else begin
            nxt.poll = cur.poll + 8'd1;
         end
      end else if (cur.delay > 16'd1) begin
         nxt.delay = cur.delay - 16'd1;
      end else begin
         nxt.delay = 16'd0;
         unique case (cur.phase)
            PH_RD_HIGH: begin
               nxt.shift = {cur.shift[6:0], cmd_in.sda_in};
               nxt.bits  = cur.bits + 4'd1;
               nxt.phase = PH_RD_HOLD; nxt.delay = dly_load;
            end
            PH_ST_A: begin
               nxt.drv = 1'b1; nxt.sda = 1'b0;
               nxt.phase = PH_ST_B; nxt.delay = dly_load;
            end
            PH_ST_B: begin
               nxt.scl = 1'b0; done = 1'b1;
            end
            PH_SP_A: begin
               nxt.scl = 1'b1; nxt.phase = PH_SP_B;
            end
            PH_SP_C: begin
               if (cur.cmd == CMD_WAIT) nxt.tflag = 1'b1;
               done = 1'b1;
            end
            PH_WR_PRE: begin
               if (cur.bits >= BITS_PER_BYTE) begin
                  done = 1'b1;
               end else begin
                  nxt.drv = 1'b1; nxt.sda = cur.shift[7];
                  nxt.shift = {cur.shift[6:0], 1'b0};
                  nxt.phase = PH_WR_DATA; nxt.delay = dly_load;
               end
            end
            PH_WR_DATA: begin
               nxt.scl = 1'b1; nxt.phase = PH_WR_HIGH; nxt.delay = dly_load;
            end
            PH_WR_HIGH: begin
               nxt.scl = 1'b0; nxt.bits = cur.bits + 4'd1;
               nxt.phase = PH_WR_PRE; nxt.delay = dly_load;
            end
            PH_RD_LOW: begin
               nxt.scl = 1'b1; nxt.phase = PH_RD_HIGH; nxt.delay = dly_load;
            end
            PH_RD_HOLD: begin
               nxt.scl = 1'b0; nxt.delay = dly_load;
               if (cur.bits < BITS_PER_BYTE) begin
                  nxt.phase = PH_RD_LOW;
               end else begin
                  nxt.rx = cur.shift;
                  nxt.drv = 1'b1; nxt.sda = ~cur.ack_choice;
                  nxt.phase = PH_RD_ACKL;
               end
            end
            PH_RD_ACKL: begin
               nxt.scl = 1'b1; nxt.phase = PH_RD_ACKH; nxt.delay = dly_load;
            end
            PH_RD_ACKH: begin
               nxt.scl = 1'b0; done = 1'b1;
            end
            PH_WA_REL: begin
               nxt.scl = 1'b1; nxt.phase = PH_WA_HIGH; nxt.delay = dly_load;
            end
            PH_WA_HIGH: begin
               nxt.phase = PH_WA_POLL; nxt.poll = 8'd0;
            end
            default: begin
               // unused phase codes fall back to idle
               done = 1'b1;
            end
         endcase
      end
      if (done) nxt.phase = PH_IDLE;
   end

endmodule
